### rtl/frwm_pkg.sv
`timescale 1ns / 1ps

package frwm_pkg;

    localparam int RATE_W     = 20;
    localparam int TIME_W     = 20;
    localparam int LEVEL_W    = 3;
    localparam int RATE_NUM_W = 28;
    localparam int CFG_IDX_W  = 2;
    localparam int WINDOW_DEF = 128;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    localparam logic [RATE_W-1:0]     RATE_MAX = 20'hFFFFF;
    localparam logic [RATE_NUM_W-1:0] RATE_NUM = 28'd256000000;

    localparam logic [LEVEL_W-1:0] LVL_CRITICAL   = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_POOR       = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_ACCEPTABLE = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_GOOD       = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_EXCELLENT  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOR       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPTABLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOOD       = 2'd3;

    localparam logic [RATE_W-1:0] THR_CRITICAL_RST   = 20'd3840;
    localparam logic [RATE_W-1:0] THR_POOR_RST       = 20'd7680;
    localparam logic [RATE_W-1:0] THR_ACCEPTABLE_RST = 20'd11520;
    localparam logic [RATE_W-1:0] THR_GOOD_RST       = 20'd15360;

    typedef struct packed {
        logic              req_type;
        logic [TIME_W-1:0] frame_time_us;
    } in_t;

    typedef struct packed {
        logic [RATE_W-1:0]  current_rate;
        logic [RATE_W-1:0]  mean_rate;
        logic [RATE_W-1:0]  min_rate;
        logic [RATE_W-1:0]  max_rate;
        logic [LEVEL_W-1:0] level;
        logic               level_changed;
        logic               critical_entered;
    } out_t;

    typedef struct packed {
        logic [RATE_W-1:0] critical;
        logic [RATE_W-1:0] poor;
        logic [RATE_W-1:0] acceptable;
        logic [RATE_W-1:0] good;
    } thr_t;

    typedef struct packed {
        logic               clear;
        logic [RATE_W-1:0]  rate;
        logic [LEVEL_W-1:0] level;
        logic               changed;
        logic               crit;
    } job_t;

endpackage

### rtl/frwm_ram.sv
`timescale 1ns / 1ps

module frwm_ram #(
    parameter int WIDTH = frwm_pkg::RATE_W,
    parameter int DEPTH = frwm_pkg::WINDOW_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/frwm_div.sv
`timescale 1ns / 1ps

module frwm_div #(
    parameter int NUM_W = frwm_pkg::RATE_NUM_W,
    parameter int DEN_W = frwm_pkg::TIME_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

### rtl/frwm_queue.sv
`timescale 1ns / 1ps

module frwm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  frwm_pkg::job_t  push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output frwm_pkg::job_t  pop_data
);

    localparam int AW = frwm_pkg::QUEUE_AW;

    frwm_pkg::job_t entries_reg [frwm_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    cnt_reg, cnt_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = cnt_reg < (AW + 1)'(frwm_pkg::QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + (AW + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - (AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/frwm_front.sv
`timescale 1ns / 1ps

module frwm_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  frwm_pkg::in_t   in_data,
    input  frwm_pkg::thr_t  thr,
    output logic            push_valid,
    input  logic            push_ready,
    output frwm_pkg::job_t  push_data
);

    localparam int RATE_W  = frwm_pkg::RATE_W;
    localparam int LEVEL_W = frwm_pkg::LEVEL_W;
    localparam int NUM_W   = frwm_pkg::RATE_NUM_W;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t         state_reg, state_next;
    logic                 clr_reg, clr_next;
    logic [RATE_W-1:0]    last_rate_reg, last_rate_next;
    logic [LEVEL_W-1:0]   cur_level_reg, cur_level_next;
    logic                 accept;
    logic                 div_start;
    logic                 div_done;
    logic [NUM_W-1:0]     div_quot;
    logic [LEVEL_W-1:0]   lvl;
    logic                 changed;

    assign in_ready  = state_reg == F_IDLE;
    assign accept    = in_valid && in_ready;
    assign div_start = accept && !in_data.req_type && (in_data.frame_time_us != '0);

    frwm_div #(
        .NUM_W (NUM_W),
        .DEN_W (frwm_pkg::TIME_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (frwm_pkg::RATE_NUM),
        .den   (in_data.frame_time_us),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        if (clr_reg)
        begin
            lvl = frwm_pkg::LVL_GOOD;
        end
        else if (last_rate_reg < thr.critical)
        begin
            lvl = frwm_pkg::LVL_CRITICAL;
        end
        else if (last_rate_reg < thr.poor)
        begin
            lvl = frwm_pkg::LVL_POOR;
        end
        else if (last_rate_reg < thr.acceptable)
        begin
            lvl = frwm_pkg::LVL_ACCEPTABLE;
        end
        else if (last_rate_reg < thr.good)
        begin
            lvl = frwm_pkg::LVL_GOOD;
        end
        else
        begin
            lvl = frwm_pkg::LVL_EXCELLENT;
        end
    end

    assign changed = !clr_reg && (lvl != cur_level_reg);

    assign push_valid        = state_reg == F_PUSH;
    assign push_data.clear   = clr_reg;
    assign push_data.rate    = last_rate_reg;
    assign push_data.level   = lvl;
    assign push_data.changed = changed;
    assign push_data.crit    = changed && (lvl == frwm_pkg::LVL_CRITICAL);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        last_rate_next = last_rate_reg;
        cur_level_next = cur_level_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    clr_next = in_data.req_type;
                    if (in_data.req_type)
                    begin
                        last_rate_next = '0;
                        state_next     = F_PUSH;
                    end
                    else if (in_data.frame_time_us == '0)
                    begin
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        state_next = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                if (div_done)
                begin
                    if (div_quot[NUM_W-1:RATE_W] != '0)
                    begin
                        last_rate_next = frwm_pkg::RATE_MAX;
                    end
                    else
                    begin
                        last_rate_next = div_quot[RATE_W-1:0];
                    end
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    cur_level_next = lvl;
                    state_next     = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            clr_reg       <= 1'b0;
            last_rate_reg <= '0;
            cur_level_reg <= frwm_pkg::LVL_GOOD;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            last_rate_reg <= last_rate_next;
            cur_level_reg <= cur_level_next;
        end
    end

endmodule

### rtl/frwm_back.sv
`timescale 1ns / 1ps

module frwm_back #(
    parameter int WINDOW = frwm_pkg::WINDOW_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  frwm_pkg::job_t  pop_data,
    output logic            out_valid,
    input  logic            out_ready,
    output frwm_pkg::out_t  out_data
);

    localparam int RATE_W = frwm_pkg::RATE_W;
    localparam int AW     = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = RATE_W + CNT_W;

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_WRITE = 5'b00010,
        B_SCAN  = 5'b00100,
        B_DIV   = 5'b01000,
        B_OUT   = 5'b10000
    } back_state_t;

    back_state_t       state_reg, state_next;
    frwm_pkg::job_t    job_reg, job_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [RATE_W-1:0] min_reg, min_next;
    logic [RATE_W-1:0] max_reg, max_next;
    logic              out_valid_reg, out_valid_next;
    frwm_pkg::out_t    out_reg, out_next;

    logic              ram_we;
    logic [RATE_W-1:0] ram_rdata;
    logic              issue;
    logic              div_start;
    logic              div_done;
    logic [SUM_W-1:0]  div_quot;
    logic              load;

    assign pop_ready = state_reg == B_IDLE;
    assign ram_we    = state_reg == B_WRITE;
    assign issue     = (state_reg == B_SCAN) && (idx_reg < count_reg);
    assign div_start = (state_reg == B_SCAN) && !issue && !pend_reg;
    assign load      = (state_reg == B_OUT) && (!out_valid_reg || out_ready);

    frwm_ram #(
        .WIDTH (RATE_W),
        .DEPTH (WINDOW)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (job_reg.rate),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    frwm_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_mean_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_reg),
        .den   (count_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        ptr_next   = ptr_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        sum_next   = sum_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    job_next = pop_data;
                    if (pop_data.clear)
                    begin
                        ptr_next   = '0;
                        count_next = '0;
                        state_next = B_OUT;
                    end
                    else
                    begin
                        state_next = B_WRITE;
                    end
                end
            end
            B_WRITE:
            begin
                ptr_next = (ptr_reg == AW'(WINDOW - 1)) ? '0 : ptr_reg + AW'(1);
                if (count_reg < CNT_W'(WINDOW))
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                idx_next   = '0;
                pend_next  = 1'b0;
                sum_next   = '0;
                min_next   = '1;
                max_next   = '0;
                state_next = B_SCAN;
            end
            B_SCAN:
            begin
                pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    sum_next = sum_reg + SUM_W'(ram_rdata);
                    if (ram_rdata < min_reg)
                    begin
                        min_next = ram_rdata;
                    end
                    if (ram_rdata > max_reg)
                    begin
                        max_next = ram_rdata;
                    end
                end
                if (div_start)
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (load)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load)
        begin
            out_valid_next            = 1'b1;
            out_next.current_rate     = job_reg.rate;
            out_next.mean_rate        = job_reg.clear ? '0 : div_quot[RATE_W-1:0];
            out_next.min_rate         = job_reg.clear ? '0 : min_reg;
            out_next.max_rate         = job_reg.clear ? '0 : max_reg;
            out_next.level            = job_reg.level;
            out_next.level_changed    = job_reg.changed;
            out_next.critical_entered = job_reg.crit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            ptr_reg       <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        sum_reg <= sum_next;
        min_reg <= min_next;
        max_reg <= max_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### rtl/frame_rate_window_monitor_core.sv
`timescale 1ns / 1ps

// frame rate monitor: each frame sample (frame time in us) gives one result with the
// current rate in unsigned q12.8 (256000000 / time, saturated, zero time keeps the last
// rate), the mean, min and max over the last WINDOW samples, a five-level class from the
// four threshold registers and change / critical-entry flags; a clear request empties
// the window and returns the class to good. the front takes a new sample only once the
// last one is pushed into the queue (a 28-step shift-subtract divider, one quotient bit
// per cycle); the back reads the window memory once per cycle for each sample held,
// then runs a bit-serial mean division (a clear skips both), and takes a new sample
// only once its last result is in the output register. a two-entry queue between
// front and back and an output register let both sides stall independently.
// thresholds must be written only while the block is idle; the block does not enforce it.

module frame_rate_window_monitor_core #(
    parameter int WINDOW = frwm_pkg::WINDOW_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  frwm_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output frwm_pkg::out_t                     out_data,
    input  logic                               cfg_we,
    input  logic [frwm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [frwm_pkg::RATE_W-1:0]        cfg_data
);

    frwm_pkg::thr_t thr_reg, thr_next;
    logic           push_valid;
    logic           push_ready;
    frwm_pkg::job_t push_data;
    logic           pop_valid;
    logic           pop_ready;
    frwm_pkg::job_t pop_data;

    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                frwm_pkg::CFG_CRITICAL:   thr_next.critical   = cfg_data;
                frwm_pkg::CFG_POOR:       thr_next.poor       = cfg_data;
                frwm_pkg::CFG_ACCEPTABLE: thr_next.acceptable = cfg_data;
                frwm_pkg::CFG_GOOD:       thr_next.good       = cfg_data;
                default:                  thr_next            = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.critical   <= frwm_pkg::THR_CRITICAL_RST;
            thr_reg.poor       <= frwm_pkg::THR_POOR_RST;
            thr_reg.acceptable <= frwm_pkg::THR_ACCEPTABLE_RST;
            thr_reg.good       <= frwm_pkg::THR_GOOD_RST;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    frwm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .thr        (thr_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    frwm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    frwm_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### tb/sv/frame_rate_window_monitor_core_test.sv
`timescale 1ns / 1ps

module frame_rate_window_monitor_core_test;

    import frwm_pkg::*;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    in_t            in_data = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    out_t           out_data;
    logic           cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [RATE_W-1:0]    cfg_data = '0;

    // predictor state
    logic [RATE_W-1:0]  rate_hist [WINDOW_DEF];
    int                 hist_wr = 0;
    int                 hist_fill = 0;
    logic [RATE_W-1:0]  held_rate = '0;
    logic [LEVEL_W-1:0] held_level = LVL_GOOD;
    thr_t               thr = {THR_CRITICAL_RST, THR_POOR_RST, THR_ACCEPTABLE_RST,
                               THR_GOOD_RST};

    out_t     pending_reports [$];
    int       report_errors = 0;
    int       reports_seen = 0;

    rx_mode_t rx_mode = RX_ALWAYS;
    int       rx_hold = 0;
    int       rx_phase = 0;
    bit       tx_bursty = 1'b0;
    int       tx_burst_left = 4;

    frame_rate_window_monitor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("frame_rate_window_monitor_core_test: errors");
        $finish;
    end

    function automatic out_t predict_report(input in_t item);
        out_t              rpt;
        int unsigned       q;
        longint unsigned   sum;
        logic [RATE_W-1:0] lo;
        logic [RATE_W-1:0] hi;
        logic [LEVEL_W-1:0] lvl;
        rpt = '0;
        if (item.req_type)
        begin
            hist_wr = 0;
            hist_fill = 0;
            held_rate = '0;
            held_level = LVL_GOOD;
            rpt.level = LVL_GOOD;
            return rpt;
        end
        if (item.frame_time_us != '0)
        begin
            q = RATE_NUM / item.frame_time_us;
            held_rate = (q > RATE_MAX) ? RATE_MAX : q[RATE_W-1:0];
        end
        rate_hist[hist_wr] = held_rate;
        hist_wr = (hist_wr + 1 == WINDOW_DEF) ? 0 : hist_wr + 1;
        if (hist_fill < WINDOW_DEF)
            hist_fill++;
        sum = 0;
        lo = rate_hist[0];
        hi = rate_hist[0];
        for (int i = 0; i < hist_fill; i++)
        begin
            sum += rate_hist[i];
            if (rate_hist[i] < lo) lo = rate_hist[i];
            if (rate_hist[i] > hi) hi = rate_hist[i];
        end
        // first threshold the rate falls under decides the class
        if (held_rate < thr.critical)        lvl = LVL_CRITICAL;
        else if (held_rate < thr.poor)       lvl = LVL_POOR;
        else if (held_rate < thr.acceptable) lvl = LVL_ACCEPTABLE;
        else if (held_rate < thr.good)       lvl = LVL_GOOD;
        else                                 lvl = LVL_EXCELLENT;
        rpt.current_rate = held_rate;
        rpt.mean_rate = RATE_W'(sum / hist_fill);
        rpt.min_rate = lo;
        rpt.max_rate = hi;
        rpt.level = lvl;
        rpt.level_changed = (lvl != held_level);
        rpt.critical_entered = (lvl != held_level) && (lvl == LVL_CRITICAL);
        held_level = lvl;
        return rpt;
    endfunction

    // receiver: long hold-off when requested, otherwise the current stall mode
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                out_ready <= 1'b0;
                rx_hold = rx_hold - 1;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS:  out_ready <= 1'b1;
                    RX_RANDOM:  out_ready <= ($urandom_range(0, 99) >= 35);
                    RX_PATTERN:
                    begin
                        out_ready <= ((rx_phase % 11) < 6);
                        rx_phase++;
                    end
                    default:    out_ready <= 1'b1;
                endcase
            end
        end
    end

    // result transfer check
    always @(posedge clk)
    begin
        out_t due;
        if (rst_n && out_valid && out_ready)
        begin
            reports_seen++;
            if (pending_reports.size() == 0)
            begin
                report_errors++;
                if (report_errors <= 10)
                    $display("report %0d: no report expected", reports_seen);
            end
            else
            begin
                due = pending_reports.pop_front();
                if (out_data.current_rate !== due.current_rate ||
                    out_data.mean_rate !== due.mean_rate ||
                    out_data.min_rate !== due.min_rate ||
                    out_data.max_rate !== due.max_rate ||
                    out_data.level !== due.level ||
                    out_data.level_changed !== due.level_changed ||
                    out_data.critical_entered !== due.critical_entered)
                begin
                    report_errors++;
                    if (report_errors <= 10)
                        $display({"report %0d: exp cur %0d mean %0d min %0d max %0d ",
                                  "lvl %0d chg %0b crit %0b, got cur %0d mean %0d ",
                                  "min %0d max %0d lvl %0d chg %0b crit %0b"},
                                 reports_seen, due.current_rate, due.mean_rate,
                                 due.min_rate, due.max_rate, due.level,
                                 due.level_changed, due.critical_entered,
                                 out_data.current_rate, out_data.mean_rate,
                                 out_data.min_rate, out_data.max_rate, out_data.level,
                                 out_data.level_changed, out_data.critical_entered);
                end
            end
        end
    end

    task automatic send_item(input in_t item);
        int gap;
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
        pending_reports.push_back(predict_report(item));
        if (tx_bursty)
        begin
            tx_burst_left--;
            if (tx_burst_left <= 0)
            begin
                in_valid <= 1'b0;
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 50);
                repeat (gap) @(posedge clk);
                tx_burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    task automatic send_sample(input logic [TIME_W-1:0] t_us);
        in_t item;
        item.req_type = 1'b0;
        item.frame_time_us = t_us;
        send_item(item);
    endtask

    task automatic send_clear(input logic [TIME_W-1:0] t_us);
        in_t item;
        item.req_type = 1'b1;
        item.frame_time_us = t_us;
        send_item(item);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_reports.size() != 0);
    endtask

    task automatic set_thresholds(input logic [RATE_W-1:0] c, input logic [RATE_W-1:0] p,
                                  input logic [RATE_W-1:0] a, input logic [RATE_W-1:0] g);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [RATE_W-1:0]    val [4];
        idx = '{CFG_CRITICAL, CFG_POOR, CFG_ACCEPTABLE, CFG_GOOD};
        val = '{c, p, a, g};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        thr.critical = c;
        thr.poor = p;
        thr.acceptable = a;
        thr.good = g;
    endtask

    function automatic logic [TIME_W-1:0] pick_frame_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return '0;
        if (r < 12) return TIME_W'($urandom_range(1, 244));
        if (r < 20) return TIME_W'($urandom);
        if (r < 25) return TIME_W'($urandom_range(240, 250));
        return TIME_W'($urandom_range(4000, 200000));
    endfunction

    task automatic send_random(input int clear_pct);
        if ($urandom_range(0, 99) < clear_pct)
            send_clear(TIME_W'($urandom));
        else
            send_sample(pick_frame_time());
    endtask

    task automatic pick_thresholds();
        int unsigned picks [$];
        for (int i = 0; i < 4; i++)
            picks.push_back(($urandom_range(0, 7) == 0) ? $urandom_range(0, RATE_MAX)
                                                        : $urandom_range(0, 70000));
        if ($urandom_range(0, 3) != 0)
            picks.sort();
        set_thresholds(RATE_W'(picks[0]), RATE_W'(picks[1]),
                       RATE_W'(picks[2]), RATE_W'(picks[3]));
    endtask

    task automatic test_directed();
        rx_mode = RX_ALWAYS;
        tx_bursty = 1'b0;
        send_clear('0);
        send_clear(RATE_MAX);
        send_sample('0);
        send_sample(20'd1);
        send_sample(20'd244);
        send_sample(20'd245);
        send_sample(20'd246);
        send_sample(RATE_MAX);
        send_sample('0);
        send_sample(20'd16667);
        send_sample(20'd16666);
        send_sample(20'd22222);
        send_sample(20'd33334);
        send_sample(20'd66667);
        send_sample(20'd66666);
        send_sample(20'd100000);
        send_sample('0);
        send_clear(20'd16666);
        send_sample('0);
        send_sample(20'd40000);
        send_sample(20'hAAAAA);
        send_sample(20'h55555);
        wait_drained();
    endtask

    task automatic test_thresholds();
        rx_mode = RX_RANDOM;
        tx_bursty = 1'b1;
        for (int s = 0; s < 7; s++)
        begin
            case (s)
                0: set_thresholds('0, '0, '0, '0);
                1: set_thresholds(RATE_MAX, RATE_MAX, RATE_MAX, RATE_MAX);
                2: set_thresholds(20'd50000, 20'd10000, 20'd30000, 20'd20000);
                3: set_thresholds(20'd1, 20'd2, RATE_MAX - 1, RATE_MAX);
                default: pick_thresholds();
            endcase
            send_sample(20'd100);
            send_sample('0);
            for (int i = 0; i < 5; i++)
                send_random(5);
            send_clear(TIME_W'($urandom));
            wait_drained();
        end
        set_thresholds(THR_CRITICAL_RST, THR_POOR_RST, THR_ACCEPTABLE_RST, THR_GOOD_RST);
    endtask

    task automatic test_window_wrap();
        rx_mode = RX_PATTERN;
        tx_bursty = 1'b1;
        send_clear('0);
        for (int i = 0; i < 160; i++)
            send_random(0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        rx_mode = RX_ALWAYS;
        tx_bursty = 1'b0;
        rx_hold = 700;
        for (int i = 0; i < 16; i++)
            send_random(3);
        wait_drained();
    endtask

    task automatic test_random();
        for (int b = 0; b < 4; b++)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            tx_bursty = $urandom_range(0, 3) != 0;
            if (b == 3)
                set_thresholds(THR_CRITICAL_RST, THR_POOR_RST, THR_ACCEPTABLE_RST,
                               THR_GOOD_RST);
            else
                pick_thresholds();
            for (int i = 0; i < 50; i++)
            begin
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
                send_random(2);
            end
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_thresholds();
        test_window_wrap();
        test_backpressure();
        test_random();
        repeat (200) @(posedge clk);
        if (report_errors == 0 && pending_reports.size() == 0)
            $display("frame_rate_window_monitor_core_test: clean");
        else
            $display("frame_rate_window_monitor_core_test: errors");
        $finish;
    end

endmodule
